// File: src/psc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, widths and codes of the polygon slab clipper.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int COORD_W     = 32;
   localparam int DIR_W       = 16;
   localparam int MPROD_W     = COORD_W + DIR_W;   // one dir * coord product
   localparam int ACC_W       = MPROD_W + 2;       // sum of three products
   localparam int PROJ_W      = ACC_W - 14;        // projection after floor shift
   localparam int DIFF_W      = PROJ_W + 1;        // bound - c and pc - c
   localparam int AMAG_W      = COORD_W + 1;       // p - v
   localparam int PROD_W      = AMAG_W + DIFF_W;   // |p - v| * |bound - c|
   localparam int CNT_W       = 7;
   localparam int MAX_RESULTS = 32;
   localparam int RES_AW      = 5;
   localparam int NRES_W      = 6;
   localparam int VERT_W      = 3 * COORD_W;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_OVF   = 2'd2;

   typedef logic signed [COORD_W-1:0] psc_coord_type;
   typedef logic signed [PROJ_W-1:0]  psc_proj_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               last_vertex;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [31:0] below_bound;
      logic signed [31:0] above_bound;
   } psc_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               last_out;
      logic [5:0]         out_count;
      logic [1:0]         status;
   } psc_rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RDV,
      ST_CAP,
      ST_PROJ,
      ST_DEC,
      ST_XCHK,
      ST_MXGO,
      ST_MXWAIT,
      ST_PUTX,
      ST_PUTV,
      ST_NEXT,
      ST_EMRD,
      ST_EMLD,
      ST_EMHOLD
   } psc_state_type;

   typedef struct packed {
      logic load;
      logic rd_vert;
      logic cap_vert;
      logic proj_step;
      logic decide;
      logic x_begin;
      logic mx_go;
      logic ax_store;
      logic put_cross;
      logic put_vert;
      logic advance;
      logic emit_init;
      logic rd_res;
      logic emit_load;
      logic emit_next;
      logic finish;
   } psc_cmd_type;

   typedef struct packed {
      logic proj_last;
      logic x_any;
      logic keep;
      logic mx_done;
      logic ax_last;
      logic walk_end;
      logic emit_last;
   } psc_status_type;

endpackage
`default_nettype wire

// File: src/polygon_slab_clipper.sv
`default_nettype none
// Loading: one vertex request per cycle while loading; the request that marks the last vertex starts the walk.
// Walk: each vertex is read, projected and decided, and put out when it is kept, plus one priming
// pass on the last vertex; the projection uses one 16x32 multiplier in four steps. Each edge
// crossing runs three axes, one after another, through one shift-add multiply and restoring
// divide unit (37 + 70 steps each). Emission: each result is read, loaded into the output
// register and held while the result side stalls; one polygon at a time. Reset clears count and overflow.
// ----------------------------------------------------------------------------
// polygon_slab_clipper
// Two-plane clipper of a convex polygon against a slab along a direction.
// ----------------------------------------------------------------------------
module polygon_slab_clipper #(
   parameter int MAX_VERTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire psc_pkg::psc_req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output psc_pkg::psc_rsp_type       rsp_data
);
   import psc_pkg::*;

   psc_cmd_type    cmd;
   psc_status_type st;

   psc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_vertex),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   psc_dp #(.MAX_VERTS(MAX_VERTS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .st       (st),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// File: src/psc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module psc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/psc_muldiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_muldiv
// Sequential (a*b)/d on magnitudes: shift-add multiply, then restoring
// divide one bit per cycle. Returns the low quotient bits with sign applied.
// ----------------------------------------------------------------------------
module psc_muldiv (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [psc_pkg::AMAG_W-1:0]   mag_a,
   input  wire logic [psc_pkg::DIFF_W-1:0]   mag_b,
   input  wire logic [psc_pkg::DIFF_W-1:0]   mag_d,
   input  wire logic                         neg,
   output logic                              done,
   output logic [psc_pkg::COORD_W-1:0]       quot
);
   import psc_pkg::*;

   logic                busy_ff, busy_in;
   logic                phase_ff, phase_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [DIFF_W-1:0]   mplier_ff, mplier_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DIFF_W-1:0]   rem_ff, rem_in;
   logic [DIFF_W-1:0]   div_ff, div_in;
   logic [COORD_W-1:0]  quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic                done_ff, done_in;
   logic [DIFF_W:0]     rem_sh;
   logic                rem_ge;

   assign rem_sh = {rem_ff, prod_ff[PROD_W-1]};
   assign rem_ge = rem_sh >= {1'b0, div_ff};

   always_comb begin
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      if (start) begin
         busy_in   = 1'b1;
         phase_in  = 1'b0;
         cnt_in    = CNT_W'(DIFF_W - 1);
         mcand_in  = PROD_W'(mag_a);
         mplier_in = mag_b;
         prod_in   = '0;
         rem_in    = '0;
         div_in    = mag_d;
         quo_in    = '0;
         neg_in    = neg;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == '0) begin
               phase_in = 1'b1;
               cnt_in   = CNT_W'(PROD_W - 1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end else begin
            // shift the next dividend bit in, subtract when it fits
            rem_in  = rem_ge ? DIFF_W'(rem_sh - {1'b0, div_ff}) : DIFF_W'(rem_sh);
            quo_in  = {quo_ff[COORD_W-2:0], rem_ge};
            prod_in = prod_ff << 1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff  <= phase_in;
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
   end

   // a zero divisor yields zero
   assign quot = (div_ff == '0) ? '0 : (neg_ff ? (~quo_ff + 1'b1) : quo_ff);
   assign done = done_ff;

endmodule
`default_nettype wire

// File: src/psc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_dp
// Clipper datapath: vertex store, projection, crossing arithmetic,
// result buffer and output register.
// ----------------------------------------------------------------------------
module psc_dp #(
   parameter int MAX_VERTS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire psc_pkg::psc_req_type     req_data,
   input  wire psc_pkg::psc_cmd_type     cmd,
   output psc_pkg::psc_status_type       st,
   output psc_pkg::psc_rsp_type          rsp_data
);
   import psc_pkg::*;

   localparam int AW   = $clog2(MAX_VERTS);
   localparam int CNTW = $clog2(MAX_VERTS + 1);

   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic signed [15:0]   dir_ff [3];
   logic signed [15:0]   dir_in [3];
   psc_coord_type        lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]        idx_ff, idx_in, last_idx_ff, last_idx_in;
   logic                 prime_ff, prime_in;
   psc_coord_type        cur_ff [3];
   psc_coord_type        cur_in [3];
   psc_coord_type        prev_ff [3];
   psc_coord_type        prev_in [3];
   psc_coord_type        cross_ff [3];
   psc_coord_type        cross_in [3];
   psc_proj_type         cur_c_ff, cur_c_in, prev_c_ff, prev_c_in;
   logic [1:0]           pj_ff, pj_in;
   logic signed [MPROD_W-1:0] mprod_ff, mprod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                 x1_en_ff, x1_en_in, x1_hi_ff, x1_hi_in;
   logic                 x2_en_ff, x2_en_in, x2_hi_ff, x2_hi_in;
   logic                 keep_ff, keep_in, sel_hi_ff, sel_hi_in;
   logic [1:0]           ax_ff, ax_in;
   logic [NRES_W-1:0]    nres_ff, nres_in, k_ff, k_in;
   psc_rsp_type          rsp_ff, rsp_in;

   logic [VERT_W-1:0]    vert_rd, res_rd, res_wr;
   logic                 res_we, nres_full, cnt_room;
   logic signed [15:0]   dsel;
   psc_coord_type        csel;
   logic signed [MPROD_W-1:0] mul_res;
   psc_proj_type         cproj, lo_e, hi_e;
   logic signed [AMAG_W-1:0]  diff_a;
   logic signed [DIFF_W-1:0]  diff_b, diff_d;
   logic [AMAG_W-1:0]    mag_a;
   logic [DIFF_W-1:0]    mag_b, mag_d;
   logic                 mx_neg, mx_done;
   logic [COORD_W-1:0]   mx_quot;
   logic [NRES_W-1:0]    k_next;
   logic [1:0]           stat_ok_code, stat_empty_code;

   assign cnt_room  = cnt_ff < CNTW'(MAX_VERTS);
   assign nres_full = nres_ff == NRES_W'(MAX_RESULTS);
   assign k_next    = k_ff + 1'b1;

   psc_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_vert_ram (
      .clock   (clock),
      .wr_en   (cmd.load && cnt_room),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data ({req_data.pos_x, req_data.pos_y, req_data.pos_z}),
      .rd_en   (cmd.rd_vert),
      .rd_addr (idx_ff),
      .rd_data (vert_rd)
   );

   assign res_we = (cmd.put_cross || cmd.put_vert) && !nres_full;
   assign res_wr = cmd.put_cross ? {cross_ff[0], cross_ff[1], cross_ff[2]}
                                 : {cur_ff[0], cur_ff[1], cur_ff[2]};

   psc_ram #(.WIDTH(VERT_W), .DEPTH(MAX_RESULTS)) u_res_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (nres_ff[RES_AW-1:0]),
      .wr_data (res_wr),
      .rd_en   (cmd.rd_res),
      .rd_addr (k_ff[RES_AW-1:0]),
      .rd_data (res_rd)
   );

   // projection: one dir * coord product per cycle
   always_comb begin
      unique case (pj_ff)
         2'd0: begin
            dsel = dir_ff[0];
            csel = cur_ff[0];
         end
         2'd1: begin
            dsel = dir_ff[1];
            csel = cur_ff[1];
         end
         2'd2: begin
            dsel = dir_ff[2];
            csel = cur_ff[2];
         end
         default: begin
            dsel = '0;
            csel = '0;
         end
      endcase
   end

   assign mul_res = dsel * csel;
   assign cproj   = PROJ_W'(acc_ff >>> 14);
   assign lo_e    = PROJ_W'(lo_ff);
   assign hi_e    = PROJ_W'(hi_ff);

   // crossing operands for the current axis
   assign diff_a = AMAG_W'(prev_ff[ax_ff]) - AMAG_W'(cur_ff[ax_ff]);
   assign diff_b = DIFF_W'(sel_hi_ff ? hi_ff : lo_ff) - DIFF_W'(cur_c_ff);
   assign diff_d = DIFF_W'(prev_c_ff) - DIFF_W'(cur_c_ff);
   assign mag_a  = diff_a[AMAG_W-1] ? AMAG_W'(-diff_a) : AMAG_W'(diff_a);
   assign mag_b  = diff_b[DIFF_W-1] ? DIFF_W'(-diff_b) : DIFF_W'(diff_b);
   assign mag_d  = diff_d[DIFF_W-1] ? DIFF_W'(-diff_d) : DIFF_W'(diff_d);
   assign mx_neg = diff_a[AMAG_W-1] ^ diff_b[DIFF_W-1] ^ diff_d[DIFF_W-1];

   psc_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.mx_go),
      .mag_a (mag_a),
      .mag_b (mag_b),
      .mag_d (mag_d),
      .neg   (mx_neg),
      .done  (mx_done),
      .quot  (mx_quot)
   );

   assign stat_ok_code    = ovf_ff ? STAT_OVF : STAT_OK;
   assign stat_empty_code = ovf_ff ? STAT_OVF : STAT_EMPTY;

   always_comb begin
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      dir_in      = dir_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      prime_in    = prime_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      cross_in    = cross_ff;
      cur_c_in    = cur_c_ff;
      prev_c_in   = prev_c_ff;
      pj_in       = pj_ff;
      mprod_in    = mprod_ff;
      acc_in      = acc_ff;
      x1_en_in    = x1_en_ff;
      x1_hi_in    = x1_hi_ff;
      x2_en_in    = x2_en_ff;
      x2_hi_in    = x2_hi_ff;
      keep_in     = keep_ff;
      sel_hi_in   = sel_hi_ff;
      ax_in       = ax_ff;
      nres_in     = nres_ff;
      k_in        = k_ff;
      rsp_in      = rsp_ff;

      if (cmd.load) begin
         if (cnt_ff == '0) begin
            dir_in[0] = req_data.dir_x;
            dir_in[1] = req_data.dir_y;
            dir_in[2] = req_data.dir_z;
            lo_in     = req_data.below_bound;
            hi_in     = req_data.above_bound;
         end
         if (cnt_room) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (req_data.last_vertex) begin
            // walk starts from the last stored vertex
            prime_in    = 1'b1;
            nres_in     = '0;
            idx_in      = cnt_room ? cnt_ff[AW-1:0] : AW'(cnt_ff - 1'b1);
            last_idx_in = cnt_room ? cnt_ff[AW-1:0] : AW'(cnt_ff - 1'b1);
         end
      end

      if (cmd.cap_vert) begin
         cur_in[0] = vert_rd[3*COORD_W-1:2*COORD_W];
         cur_in[1] = vert_rd[2*COORD_W-1:COORD_W];
         cur_in[2] = vert_rd[COORD_W-1:0];
         pj_in     = '0;
         acc_in    = '0;
      end

      if (cmd.proj_step) begin
         mprod_in = mul_res;
         if (pj_ff != 2'd0) begin
            acc_in = acc_ff + ACC_W'(mprod_ff);
         end
         pj_in = pj_ff + 1'b1;
      end

      if (cmd.decide) begin
         cur_c_in = cproj;
         x1_en_in = 1'b0;
         x1_hi_in = 1'b0;
         x2_en_in = 1'b0;
         x2_hi_in = 1'b0;
         keep_in  = 1'b0;
         if (!prime_ff) begin
            priority if (cproj < lo_e) begin
               x1_en_in = prev_c_ff > hi_e;
               x1_hi_in = 1'b1;
               x2_en_in = prev_c_ff > lo_e;
            end else if (cproj > hi_e) begin
               x1_en_in = prev_c_ff < lo_e;
               x2_en_in = prev_c_ff < hi_e;
               x2_hi_in = 1'b1;
            end else begin
               x1_en_in = (prev_c_ff < lo_e && cproj > lo_e) ||
                          (prev_c_ff > hi_e && cproj < hi_e);
               x1_hi_in = !(prev_c_ff < lo_e);
               keep_in  = 1'b1;
            end
         end
      end

      if (cmd.x_begin) begin
         ax_in = '0;
         if (x1_en_ff) begin
            sel_hi_in = x1_hi_ff;
            x1_en_in  = 1'b0;
         end else begin
            sel_hi_in = x2_hi_ff;
            x2_en_in  = 1'b0;
         end
      end

      if (cmd.ax_store) begin
         cross_in[ax_ff] = cur_ff[ax_ff] + mx_quot;
         ax_in           = ax_ff + 1'b1;
      end

      if (res_we) begin
         nres_in = nres_ff + 1'b1;
      end

      if (cmd.advance) begin
         prev_in   = cur_ff;
         prev_c_in = cur_c_ff;
         if (prime_ff) begin
            prime_in = 1'b0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (cmd.emit_init) begin
         k_in = '0;
      end

      if (cmd.emit_load) begin
         if (nres_ff == '0) begin
            rsp_in.out_x     = '0;
            rsp_in.out_y     = '0;
            rsp_in.out_z     = '0;
            rsp_in.last_out  = 1'b1;
            rsp_in.out_count = '0;
            rsp_in.status    = stat_empty_code;
         end else begin
            rsp_in.out_x     = res_rd[3*COORD_W-1:2*COORD_W];
            rsp_in.out_y     = res_rd[2*COORD_W-1:COORD_W];
            rsp_in.out_z     = res_rd[COORD_W-1:0];
            rsp_in.last_out  = k_next == nres_ff;
            rsp_in.out_count = nres_ff;
            rsp_in.status    = stat_ok_code;
         end
      end

      if (cmd.emit_next) begin
         k_in = k_next;
      end

      if (cmd.finish) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
      dir_ff      <= dir_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      prime_ff    <= prime_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      cross_ff    <= cross_in;
      cur_c_ff    <= cur_c_in;
      prev_c_ff   <= prev_c_in;
      pj_ff       <= pj_in;
      mprod_ff    <= mprod_in;
      acc_ff      <= acc_in;
      x1_en_ff    <= x1_en_in;
      x1_hi_ff    <= x1_hi_in;
      x2_en_ff    <= x2_en_in;
      x2_hi_ff    <= x2_hi_in;
      keep_ff     <= keep_in;
      sel_hi_ff   <= sel_hi_in;
      ax_ff       <= ax_in;
      nres_ff     <= nres_in;
      k_ff        <= k_in;
      rsp_ff      <= rsp_in;
   end

   assign st.proj_last = pj_ff == 2'd3;
   assign st.x_any     = x1_en_ff || x2_en_ff;
   assign st.keep      = keep_ff;
   assign st.mx_done   = mx_done;
   assign st.ax_last   = ax_ff == 2'd2;
   assign st.walk_end  = !prime_ff && (idx_ff == last_idx_ff);
   assign st.emit_last = (nres_ff == '0) || (k_next == nres_ff);

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: src/psc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_ctrl
// Clipper sequencer: load, edge walk with crossings, result emission.
// ----------------------------------------------------------------------------
module psc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_last,
   input  wire logic                       rsp_stall,
   input  wire psc_pkg::psc_status_type    st,
   output psc_pkg::psc_cmd_type            cmd,
   output logic                            req_stall,
   output logic                            rsp_valid
);
   import psc_pkg::*;

   psc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_RDV;
               end
            end
         end
         ST_RDV: begin
            cmd.rd_vert = 1'b1;
            state_in    = ST_CAP;
         end
         ST_CAP: begin
            cmd.cap_vert = 1'b1;
            state_in     = ST_PROJ;
         end
         ST_PROJ: begin
            cmd.proj_step = 1'b1;
            if (st.proj_last) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            cmd.decide = 1'b1;
            state_in   = ST_XCHK;
         end
         ST_XCHK: begin
            priority if (st.x_any) begin
               cmd.x_begin = 1'b1;
               state_in    = ST_MXGO;
            end else if (st.keep) begin
               state_in = ST_PUTV;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_MXGO: begin
            cmd.mx_go = 1'b1;
            state_in  = ST_MXWAIT;
         end
         ST_MXWAIT: begin
            if (st.mx_done) begin
               cmd.ax_store = 1'b1;
               state_in     = st.ax_last ? ST_PUTX : ST_MXGO;
            end
         end
         ST_PUTX: begin
            cmd.put_cross = 1'b1;
            state_in      = ST_XCHK;
         end
         ST_PUTV: begin
            cmd.put_vert = 1'b1;
            state_in     = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.advance = 1'b1;
            if (st.walk_end) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMRD;
            end else begin
               state_in = ST_RDV;
            end
         end
         ST_EMRD: begin
            cmd.rd_res = 1'b1;
            state_in   = ST_EMLD;
         end
         ST_EMLD: begin
            cmd.emit_load = 1'b1;
            state_in      = ST_EMHOLD;
         end
         ST_EMHOLD: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.emit_next = 1'b1;
               if (st.emit_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_EMRD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polygon_slab_clipper. An initial block queues
// polygon vertex requests, directed first and then random. A clocked driver
// sends them with random idle bursts. A clocked monitor stalls the result side
// at random and checks every clipped vertex against a local slab clipper model.
// ----------------------------------------------------------------------------
module testbench;
   import psc_pkg::*;

   localparam int NVERT      = 16;
   localparam int WATCH_LIMIT = 60000;
   localparam int QUIET_ITEMS = 40;

   typedef struct {
      psc_req_type req;
      bit          hold;      // wait for all clipped vertices before sending
   } vertex_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   psc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   psc_rsp_type rsp_data;

   vertex_entry_type vertex_q[$];
   psc_rsp_type      clipped_q[$];
   bit               quiet = 1'b0;
   bit               fill_done = 1'b0;
   int               errors = 0;
   int               idle_left = 0;
   int               stall_left = 0;
   int               watch = 0;

   // model state
   longint st_x[NVERT], st_y[NVERT], st_z[NVERT];
   int     n_loaded = 0;
   longint m_dir[3];
   longint m_lo, m_hi;
   bit     m_ovf = 1'b0;
   psc_rsp_type pts[MAX_RESULTS];
   int     n_pts;

   polygon_slab_clipper i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint project(longint x, longint y, longint z);
      longint s;
      s = m_dir[0] * x + m_dir[1] * y + m_dir[2] * z;
      return s >>> 14;
   endfunction

   function automatic logic [31:0] cross_axis(longint pv, longint vv, longint b, longint d);
      logic signed [127:0] na, nb, nd, q;
      na = pv - vv;
      nb = b;
      nd = d;
      if (d == 0) q = '0;
      else q = (na * nb) / nd;
      return vv[31:0] + q[31:0];
   endfunction

   function automatic void add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (n_pts >= MAX_RESULTS) return;
      pts[n_pts] = '0;
      pts[n_pts].out_x = x;
      pts[n_pts].out_y = y;
      pts[n_pts].out_z = z;
      n_pts++;
   endfunction

   function automatic void add_cross(int pi, int vi, longint bound, longint c, longint pc);
      longint b, d;
      b = bound - c;
      d = pc - c;
      add_point(cross_axis(st_x[pi], st_x[vi], b, d), cross_axis(st_y[pi], st_y[vi], b, d),
                cross_axis(st_z[pi], st_z[vi], b, d));
   endfunction

   function automatic logic [1:0] m_ovf_or_empty(logic [1:0] stat);
      return (stat == STAT_OVF) ? STAT_OVF : STAT_EMPTY;
   endfunction

   function automatic void clip_vertex(psc_req_type r);
      int pi;
      longint c, pc;
      logic [1:0] stat;
      psc_rsp_type e;
      if (n_loaded == 0) begin
         m_dir[0] = r.dir_x;
         m_dir[1] = r.dir_y;
         m_dir[2] = r.dir_z;
         m_lo = r.below_bound;
         m_hi = r.above_bound;
      end
      if (n_loaded < NVERT) begin
         st_x[n_loaded] = r.pos_x;
         st_y[n_loaded] = r.pos_y;
         st_z[n_loaded] = r.pos_z;
         n_loaded++;
      end else begin
         m_ovf = 1'b1;
      end
      if (!r.last_vertex) return;
      n_pts = 0;
      pi = n_loaded - 1;
      pc = project(st_x[pi], st_y[pi], st_z[pi]);
      for (int i = 0; i < n_loaded; i++) begin
         c = project(st_x[i], st_y[i], st_z[i]);
         if (c < m_lo) begin
            if (pc > m_hi) add_cross(pi, i, m_hi, c, pc);
            if (pc > m_lo) add_cross(pi, i, m_lo, c, pc);
         end else if (c > m_hi) begin
            if (pc < m_lo) add_cross(pi, i, m_lo, c, pc);
            if (pc < m_hi) add_cross(pi, i, m_hi, c, pc);
         end else begin
            if (pc < m_lo) begin
               if (c > m_lo) add_cross(pi, i, m_lo, c, pc);
            end else if (pc > m_hi && c < m_hi) begin
               add_cross(pi, i, m_hi, c, pc);
            end
            add_point(st_x[i][31:0], st_y[i][31:0], st_z[i][31:0]);
         end
         pi = i;
         pc = c;
      end
      stat = m_ovf ? STAT_OVF : STAT_OK;
      n_loaded = 0;
      m_ovf = 1'b0;
      if (n_pts == 0) begin
         e = '0;
         e.last_out = 1'b1;
         e.status = m_ovf_or_empty(stat);
         clipped_q.push_back(e);
      end else begin
         for (int k = 0; k < n_pts; k++) begin
            e = pts[k];
            e.last_out = (k == n_pts - 1);
            e.out_count = n_pts[5:0];
            e.status = stat;
            clipped_q.push_back(e);
         end
      end
   endfunction

   function automatic int small_val(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // one polygon: mode 0 moderate values, mode 1 full-range junk
   task automatic queue_polygon(int nv, int mode, bit hold);
      vertex_entry_type ent;
      int lo, hi, t;
      logic [223:0] junk;
      lo = small_val(1 << 20);
      hi = small_val(1 << 20);
      if (lo > hi && $urandom_range(0, 7) != 0) begin
         t = lo; lo = hi; hi = t;
      end
      for (int i = 0; i < nv; i++) begin
         ent.hold = hold && (i == 0);
         ent.req = '0;
         if (mode == 1) begin
            junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            ent.req = junk[$bits(psc_req_type)-1:0];
         end else begin
            ent.req.pos_x = small_val(1 << 20);
            ent.req.pos_y = small_val(1 << 20);
            ent.req.pos_z = small_val(1 << 20);
            ent.req.dir_x = 16'($urandom);
            ent.req.dir_y = 16'($urandom);
            ent.req.dir_z = 16'($urandom);
            ent.req.below_bound = (i == 0) ? lo : $urandom;
            ent.req.above_bound = (i == 0) ? hi : $urandom;
         end
         ent.req.last_vertex = (i == nv - 1);
         vertex_q.push_back(ent);
      end
   endtask

   task automatic queue_axis_vertex(int x, int y, int z, int lo, int hi, bit last);
      vertex_entry_type ent;
      ent.hold = 1'b0;
      ent.req = '0;
      ent.req.pos_x = x;
      ent.req.pos_y = y;
      ent.req.pos_z = z;
      ent.req.dir_x = 16'sd16384;
      ent.req.below_bound = lo;
      ent.req.above_bound = hi;
      ent.req.last_vertex = last;
      vertex_q.push_back(ent);
   endtask

   initial begin
      int total, nv;
      // all below the slab: empty result
      queue_axis_vertex(-5000, 1, 2, -100, 100, 0);
      queue_axis_vertex(-6000, 300, 0, 0, 0, 0);
      queue_axis_vertex(-7000, -300, 9, 0, 0, 1);
      // single vertex inside, then a two-vertex span
      queue_axis_vertex(50, -50, 7, -100, 100, 1);
      queue_axis_vertex(-1000, 20, 30, -100, 100, 0);
      queue_axis_vertex(1000, -20, -30, 0, 0, 1);
      // alternating below and above: the full result count
      for (int i = 0; i < 16; i++)
         queue_axis_vertex((i % 2) ? 1000 : -1000, i * 64, -i * 32, -100, 100, i == 15);
      // inverted bounds
      queue_axis_vertex(-300, 0, 0, 200, -200, 0);
      queue_axis_vertex(300, 10, 0, 0, 0, 0);
      queue_axis_vertex(0, 500, 5, 0, 0, 1);
      // extreme values, with overflow past the vertex store
      for (int i = 0; i < 18; i++) begin
         vertex_entry_type ent;
         ent.hold = (i == 0);
         ent.req.pos_x = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
         ent.req.pos_y = (i % 3) ? 32'sh80000000 : 32'sh7fffffff;
         ent.req.pos_z = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
         ent.req.dir_x = (i % 2) ? 16'sh7fff : 16'sh8000;
         ent.req.dir_y = 16'sh8000;
         ent.req.dir_z = 16'sh7fff;
         ent.req.below_bound = 32'sh80000000;
         ent.req.above_bound = 32'sh7fffffff;
         ent.req.last_vertex = (i == 17);
         vertex_q.push_back(ent);
      end
      total = vertex_q.size();
      while (total < 330) begin
         nv = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 9);
         queue_polygon(nv, ($urandom_range(0, 5) == 0), ($urandom_range(0, 7) == 0));
         total += nv;
      end
      fill_done = 1'b1;
   end

   // request driver and prediction on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) clip_vertex(req_data);
         if (!req_valid || !req_stall) begin
            if (fill_done && vertex_q.size() < QUIET_ITEMS) quiet <= 1'b1;
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               req_valid <= 1'b0;
            end else if (vertex_q.size() > 0 && fill_done &&
                         !(vertex_q[0].hold && clipped_q.size() > 0)) begin
               req_valid <= 1'b1;
               req_data <= vertex_q[0].req;
               vertex_q.pop_front();
               if (!quiet && $urandom_range(0, 5) == 0) idle_left <= $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      psc_rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (clipped_q.size() == 0) begin
               $error("unexpected clipped vertex %h", rsp_data);
               errors++;
            end else begin
               e = clipped_q.pop_front();
               if (rsp_data.out_x !== e.out_x) begin
                  $error("out_x expected %h actual %h", e.out_x, rsp_data.out_x); errors++;
               end
               if (rsp_data.out_y !== e.out_y) begin
                  $error("out_y expected %h actual %h", e.out_y, rsp_data.out_y); errors++;
               end
               if (rsp_data.out_z !== e.out_z) begin
                  $error("out_z expected %h actual %h", e.out_z, rsp_data.out_z); errors++;
               end
               if (rsp_data.last_out !== e.last_out) begin
                  $error("last_out expected %h actual %h", e.last_out, rsp_data.last_out);
                  errors++;
               end
               if (rsp_data.out_count !== e.out_count) begin
                  $error("out_count expected %0d actual %0d", e.out_count, rsp_data.out_count);
                  errors++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 7);
         end
      end
   end

   // watchdog: cycles without any accepted transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (fill_done);
      while (vertex_q.size() > 0 || req_valid || clipped_q.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (clipped_q.size() != 0) begin
         $error("%0d clipped vertices never arrived", clipped_q.size());
         errors++;
      end
      if (errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule

// File: files.f
src/psc_pkg.sv
src/psc_ram.sv
src/psc_muldiv.sv
src/psc_dp.sv
src/psc_ctrl.sv
src/polygon_slab_clipper.sv
test/testbench.sv
